// ===== hdl/base64_base32_encoder_defines.svh =====
// Assertion macros for the Base64 / Base32 encoder
`ifndef BASE64_BASE32_ENCODER_DEFINES_SVH
`define BASE64_BASE32_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

// check a condition at every clock edge outside reset
`define B64B32_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("encoder assertion failed");

// check a consequence in the same cycle
`define B64B32_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("encoder assertion failed");

// check a consequence in the next cycle
`define B64B32_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("encoder assertion failed");

`else

`define B64B32_ASSERT_ALWAYS(label, expr)
`define B64B32_ASSERT_IMPL(label, ante, cons)
`define B64B32_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hdl/b64b32_pkg.sv =====
// Types, constants and alphabet functions of the Base64 / Base32 encoder
`default_nettype none

package b64b32_pkg;

   typedef enum logic {
      MODE_BASE64 = 1'b0,
      MODE_BASE32 = 1'b1
   } mode_type;

   localparam logic [6:0] PAD_CHAR      = 7'h3D;
   localparam logic [2:0] GROUP_BASE64  = 3'd6;
   localparam logic [2:0] GROUP_BASE32  = 3'd5;
   localparam logic [2:0] LAST_SLOT     = 3'd7;

   // standard Base64 alphabet
   function automatic logic [6:0] b64_char(input logic [5:0] grp);
      priority if (grp < 6'd26) begin
         return 7'h41 + {1'b0, grp};
      end else if (grp < 6'd52) begin
         return 7'h61 + {1'b0, grp} - 7'd26;
      end else if (grp < 6'd62) begin
         return 7'h30 + {1'b0, grp} - 7'd52;
      end else if (grp == 6'd62) begin
         return 7'h2B;
      end else begin
         return 7'h2F;
      end
   endfunction

   // standard Base32 alphabet
   function automatic logic [6:0] b32_char(input logic [4:0] grp);
      priority if (grp < 5'd26) begin
         return 7'h41 + {2'b0, grp};
      end else begin
         return 7'h32 + {2'b0, grp} - 7'd26;
      end
   endfunction

   // padding still owed for a character count modulo 8
   function automatic logic pad_needed(input mode_type mode, input logic [2:0] chars);
      unique case (mode)
         MODE_BASE32: return chars != 3'd0;
         MODE_BASE64: return chars[1:0] != 2'd0;
         default:     return 1'b0;
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== hdl/base64_base32_encoder.sv =====
// Streaming Base64 / Base32 encoder, top level
//
// Usage:
//  - req channel: one message byte per beat (req_data_byte) with req_last_byte
//    set on the final byte. Empty messages are not supported.
//  - rsp channel: one ASCII character per beat (rsp_out_char); rsp_last_char
//    marks the final character of a message, after any '=' padding.
//  - csr port: csr_write_enable writes csr_alphabet_mode (0 = Base64,
//    1 = Base32). Write only while no message byte is in flight.
// Path: a byte taken goes into the work register; each of its characters is
// then formed from it and registered in the output register.
// Throughput: one character per cycle while rsp_stall is low; a byte stays in
// the work register until it has given all its characters - one or two for an
// inner byte, up to eight for a final byte with flush and padding. The next
// byte is taken in the same cycle as the final character of the current one
// leaves the work register, so a steady stream runs with no bubbles.
// Reset (synchronous, active high): empties both registers, clears the bit
// accumulator, pending bit count and character count, and selects Base64.
// Stall: while rsp_stall holds, the character waits in the output register,
// the work register holds, and req_stall rises once the work register is full.
`default_nettype none

`include "base64_base32_encoder_defines.svh"

module base64_base32_encoder
   import b64b32_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_alphabet_mode,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [6:0]      rsp_out_char,
   output logic            rsp_last_char
);

   // configuration
   mode_type    mode_ff, mode_in;

   // work register: accumulator, pending bit count, message character count
   logic        work_valid_ff, work_valid_in;
   logic [11:0] acc_ff, acc_in;
   logic [3:0]  pend_ff, pend_in;
   logic [2:0]  chars_ff, chars_in;
   logic        last_ff, last_in;
   logic [2:0]  count_ff, count_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [6:0]  rsp_char_ff, rsp_char_in;
   logic        rsp_lastc_ff, rsp_lastc_in;

   logic [2:0]  gsize;
   logic        has_group;
   logic [3:0]  shift_amt;
   logic [11:0] shifted;
   logic [11:0] flushed;
   logic [5:0]  grp_bits;
   logic [6:0]  alpha_char;
   logic [6:0]  step_char;
   logic [3:0]  new_pend;
   logic [2:0]  new_chars;
   logic        more;
   logic        out_free;
   logic        emit;
   logic        done;
   logic        accept;

   // character step: a full group, else the zero-filled tail, else padding
   always_comb begin
      unique case (mode_ff)
         MODE_BASE32: gsize = GROUP_BASE32;
         MODE_BASE64: gsize = GROUP_BASE64;
         default:     gsize = GROUP_BASE64;
      endcase
      has_group  = pend_ff >= {1'b0, gsize};
      shift_amt  = pend_ff - {1'b0, gsize};
      // a bit above bit 11 reads as zero
      shifted    = acc_ff >> shift_amt;
      flushed    = acc_ff << (gsize - pend_ff[2:0]);
      grp_bits   = has_group ? shifted[5:0] : flushed[5:0];
      alpha_char = (mode_ff == MODE_BASE32) ? b32_char(grp_bits[4:0]) : b64_char(grp_bits);
      step_char  = (has_group || (last_ff && (pend_ff != 4'd0))) ? alpha_char : PAD_CHAR;
      new_pend   = has_group ? shift_amt : 4'd0;
      new_chars  = chars_ff + 3'd1;
      // anything left after this character; the eighth one always ends it
      more       = (count_ff != LAST_SLOT)
                   && ((new_pend >= {1'b0, gsize})
                       || (last_ff && ((new_pend != 4'd0) || pad_needed(mode_ff, new_chars))));
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = work_valid_ff && out_free;
   assign done      = emit && !more;
   assign req_stall = work_valid_ff && !done;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      mode_in       = csr_write_enable ? mode_type'(csr_alphabet_mode) : mode_ff;
      work_valid_in = work_valid_ff;
      acc_in        = acc_ff;
      pend_in       = pend_ff;
      chars_in      = chars_ff;
      last_in       = last_ff;
      count_in      = count_ff;

      // advance through the characters of the current byte
      if (emit) begin
         pend_in  = new_pend;
         chars_in = new_chars;
         count_in = count_ff + 3'd1;
         if (done) begin
            work_valid_in = 1'b0;
            // a finished message leaves no state behind
            if (last_ff) begin
               acc_in   = '0;
               pend_in  = '0;
               chars_in = '0;
            end
         end
      end

      // shift the new byte in on top of what the last character left
      if (accept) begin
         work_valid_in = 1'b1;
         acc_in        = {acc_in[3:0], req_data_byte};
         pend_in       = pend_in + 4'd8;
         last_in       = req_last_byte;
         count_in      = '0;
      end

      rsp_valid_in = out_free ? emit : rsp_valid_ff;
      rsp_char_in  = emit ? step_char : rsp_char_ff;
      rsp_lastc_in = emit ? (last_ff && !more) : rsp_lastc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_BASE64;
         work_valid_ff <= 1'b0;
         acc_ff        <= '0;
         pend_ff       <= '0;
         chars_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         work_valid_ff <= work_valid_in;
         acc_ff        <= acc_in;
         pend_ff       <= pend_in;
         chars_ff      <= chars_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      count_ff     <= count_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_lastc_ff <= rsp_lastc_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_last_char = rsp_lastc_ff;

   // at most five bits stay behind after a byte, so at most thirteen with a new one
   `B64B32_ASSERT_ALWAYS(a_pend_range, pend_ff <= 4'd13)
   // between bytes the leftover is always less than a whole Base64 group
   `B64B32_ASSERT_IMPL(a_idle_pend, !work_valid_ff, pend_ff <= 4'd5)
   // the character count restarts once a message is finished
   `B64B32_ASSERT_NEXT(a_msg_clear, done && last_ff, chars_ff == 3'd0)

endmodule

`default_nettype wire
